// ===== sv/grid_keypoint_suppression_macros.svh =====
// assertion macros for the grid keypoint suppression block
`ifndef GRID_KEYPOINT_SUPPRESSION_MACROS_SVH
`define GRID_KEYPOINT_SUPPRESSION_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gks assertion failed");
// next-cycle implication
`define GKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gks assertion failed");
`else
`define GKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/gks_pkg.sv =====
// shared constants and types of the grid keypoint suppression block
package gks_pkg;

    localparam int CELL_SIZE = 10;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int PTR_W     = $clog2(2 * NUM_CELLS);

    localparam int COORD_W   = 12;
    localparam int STR_W     = 16;
    localparam int POINT_W   = 2 * COORD_W + STR_W;

    // floor reciprocal of the cell size, scaled by 2^RECIP_SH
    localparam int RECIP_SH  = 16;
    localparam int RECIP     = (1 << RECIP_SH) / CELL_SIZE;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int CS_W      = $clog2(CELL_SIZE + 1);
    localparam int PROD_W    = COORD_W + CS_W;
    localparam int ROWMUL_W  = COORD_W + 9;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FETCH  = 1'b1;

    typedef struct packed {
        logic [STR_W-1:0]   strength;
        logic [COORD_W-1:0] y_pos;
        logic [COORD_W-1:0] x_pos;
    } t_point;

    typedef struct packed {
        logic   occ;
        t_point pt;
    } t_cell_entry;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
    } t_idx_req;

    typedef struct packed {
        logic              valid;
        logic              in_grid;
        logic [CELL_W-1:0] cell_idx;
    } t_idx_res;

endpackage

// ===== sv/gks_cell_index.sv =====
// cell index unit: coordinates to grid cell, three register stages
module gks_cell_index
    import gks_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_idx_req i_req,
    output t_idx_res o_res
);

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [CS_W-1:0]    CS_C    = CS_W'(CELL_SIZE);

    // stage 1: reciprocal products
    logic                       r_v1;
    logic [COORD_W-1:0]         r_x1, r_y1;
    logic [COORD_W+RECIP_W-1:0] r_px1, r_py1;
    // stage 2: corrected quotients
    logic                       r_v2;
    logic [COORD_W-1:0]         r_col2, r_row2;
    // stage 3: result
    t_idx_res                   r_res;

    logic [COORD_W-1:0]  w_qx, w_qy, w_col, w_row;
    logic [PROD_W-1:0]   w_bx, w_by;
    logic [PROD_W:0]     w_limx, w_limy;
    logic [ROWMUL_W-1:0] w_lin;
    logic                w_in;

    always_comb begin
        w_qx   = r_px1[RECIP_SH +: COORD_W];
        w_qy   = r_py1[RECIP_SH +: COORD_W];
        w_bx   = PROD_W'(w_qx) * PROD_W'(CS_C);
        w_by   = PROD_W'(w_qy) * PROD_W'(CS_C);
        w_limx = {1'b0, w_bx} + (PROD_W+1)'(CS_C);
        w_limy = {1'b0, w_by} + (PROD_W+1)'(CS_C);
        // estimate is low by at most one
        w_col  = ((PROD_W+1)'(r_x1) >= w_limx) ? w_qx + 1'b1 : w_qx;
        w_row  = ((PROD_W+1)'(r_y1) >= w_limy) ? w_qy + 1'b1 : w_qy;
        w_in   = (32'(r_col2) < GRID_COLS) && (32'(r_row2) < GRID_ROWS);
        w_lin  = ROWMUL_W'(r_row2) * ROWMUL_W'(GRID_COLS) + ROWMUL_W'(r_col2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_v1        <= i_req.valid;
            r_v2        <= r_v1;
            r_res.valid <= r_v2;
        end
        r_x1           <= i_req.x_pos;
        r_y1           <= i_req.y_pos;
        r_px1          <= (COORD_W+RECIP_W)'(i_req.x_pos) * (COORD_W+RECIP_W)'(RECIP_C);
        r_py1          <= (COORD_W+RECIP_W)'(i_req.y_pos) * (COORD_W+RECIP_W)'(RECIP_C);
        r_col2         <= w_col;
        r_row2         <= w_row;
        r_res.in_grid  <= w_in;
        r_res.cell_idx <= w_lin[CELL_W-1:0];
    end

    assign o_res = r_res;

endmodule

// ===== sv/grid_keypoint_suppression.sv =====
// top level of the grid keypoint suppression block
//
// keeps the strongest keypoint of every CELL_SIZE x CELL_SIZE pixel cell
// input channel s_axis: tuser selects insert (0) or fetch (1), tdata carries
// x, y and strength of a keypoint (used by insert only)
// output channel m_axis: one transaction per fetch, none per insert
//   tuser 1: a kept keypoint is returned, tlast marks the one that empties
//   the list; tuser 0: list was empty, tdata and tlast are zero
// keypoints come out in the order their cells were first occupied
// an insert passes the index pipeline, then reads its cell and writes it back;
// one that falls off the grid ends after the index pipeline; a fetch reads the
// list memory, then the cell memory, then loads the output register, and on an
// empty list goes straight to the output load; throughput: one item at a time,
// set by the index pipeline and the read-modify-write of the cell memory and
// the occupancy list memory, both with registered read ports
// reset: a clearing pass sweeps all NUM_CELLS (4096 here) cells of the cell
// memory, one cell per cycle; tready stays low until it ends
// receiver stall: the result sits in an output register; the next item is
// still accepted, and only a fetch that finds the register full waits
`include "grid_keypoint_suppression_macros.svh"

module grid_keypoint_suppression
    import gks_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [POINT_W-1:0] s_axis_tdata,  // x_pos, y_pos, strength
    input  logic               s_axis_tuser,  // req_type
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [POINT_W-1:0] m_axis_tdata,  // out_x, out_y, out_strength
    output logic               m_axis_tuser,  // out_valid
    output logic               m_axis_tlast   // out_last
);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_IDX   = 3'd2;  // waiting for the cell index
    localparam logic [2:0] S_IRD   = 3'd3;  // cell memory read in flight
    localparam logic [2:0] S_IWR   = 3'd4;  // compare and write back
    localparam logic [2:0] S_FLST  = 3'd5;  // list entry read back, cell memory read issued
    localparam logic [2:0] S_FCEL  = 3'd6;  // cell memory read in flight
    localparam logic [2:0] S_FOUT  = 3'd7;  // load output, release the cell

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(2 * NUM_CELLS - 1);
    localparam logic [PTR_W-1:0]  PTR_CELLS = PTR_W'(NUM_CELLS);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(NUM_CELLS - 1);

    // list position of a pointer counted modulo twice the depth
    function automatic logic [CELL_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] v;
        v = (p >= PTR_CELLS) ? p - PTR_CELLS : p;
        return v[CELL_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // memories
    t_cell_entry       cell_mem [NUM_CELLS];
    logic [CELL_W-1:0] list_mem [NUM_CELLS];

    logic [2:0]        r_state, n_state;
    logic [CELL_W-1:0] r_clr_cnt;
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    t_point            r_pt;
    logic [CELL_W-1:0] r_cell;
    logic              r_hit;

    t_cell_entry       r_cell_q;
    logic [CELL_W-1:0] r_list_q;

    // output register
    logic              r_out_valid;
    t_point            r_out_data;
    logic              r_out_hit;
    logic              r_out_last;

    t_idx_req          w_idx_req;
    t_idx_res          w_idx_res;

    logic              w_accept;
    logic              w_empty;
    logic              w_out_load;
    logic              w_cell_we, w_cell_re, w_list_we, w_list_re;
    logic [CELL_W-1:0] w_cell_waddr, w_cell_raddr;
    t_cell_entry       w_cell_wdata;
    logic [PTR_W-1:0]  w_fill;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_empty       = (r_rd_ptr == r_wr_ptr);
    assign w_out_load    = (r_state == S_FOUT) && (!r_out_valid || m_axis_tready);

    assign w_idx_req.valid = w_accept && (s_axis_tuser == REQ_INSERT);
    assign w_idx_req.x_pos = s_axis_tdata[COORD_W-1:0];
    assign w_idx_req.y_pos = s_axis_tdata[2*COORD_W-1:COORD_W];

    gks_cell_index u_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_idx_req),
        .o_res   (w_idx_res)
    );

    // memory port control, next state and next pointers
    always_comb begin
        w_cell_we    = 1'b0;
        w_cell_re    = 1'b0;
        w_list_we    = 1'b0;
        w_list_re    = 1'b0;
        w_cell_waddr = r_cell;
        w_cell_raddr = r_cell;
        w_cell_wdata = '0;
        n_state      = r_state;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        unique case (r_state)
            S_CLEAR: begin
                w_cell_we    = 1'b1;
                w_cell_waddr = r_clr_cnt;
                if (r_clr_cnt == CELL_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == REQ_INSERT) begin
                        n_state = S_IDX;
                    end else if (w_empty) begin
                        n_state = S_FOUT;
                    end else begin
                        w_list_re = 1'b1;
                        n_state   = S_FLST;
                    end
                end
            end
            S_IDX: begin
                if (w_idx_res.valid) begin
                    if (w_idx_res.in_grid) begin
                        w_cell_re    = 1'b1;
                        w_cell_raddr = w_idx_res.cell_idx;
                        n_state      = S_IRD;
                    end else begin
                        // outside the grid: dropped
                        n_state = S_IDLE;
                    end
                end
            end
            S_IRD: begin
                n_state = S_IWR;
            end
            S_IWR: begin
                w_cell_wdata.occ = 1'b1;
                w_cell_wdata.pt  = r_pt;
                if (!r_cell_q.occ) begin
                    // first keypoint of the cell: store and append to the list
                    w_cell_we = 1'b1;
                    w_list_we = 1'b1;
                    n_wr_ptr  = ptr_inc(r_wr_ptr);
                end else if (r_pt.strength > r_cell_q.pt.strength) begin
                    w_cell_we = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_FLST: begin
                w_cell_re    = 1'b1;
                w_cell_raddr = r_list_q;
                n_state      = S_FCEL;
            end
            S_FCEL: begin
                n_state = S_FOUT;
            end
            S_FOUT: begin
                if (w_out_load) begin
                    if (r_hit) begin
                        // release the cell
                        w_cell_we    = 1'b1;
                        w_cell_waddr = r_cell;
                        n_rd_ptr     = ptr_inc(r_rd_ptr);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell memory and occupancy list memory
    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            cell_mem[w_cell_waddr] <= w_cell_wdata;
        end
        if (w_cell_re) begin
            r_cell_q <= cell_mem[w_cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            list_mem[ptr_index(r_wr_ptr)] <= r_cell;
        end
        if (w_list_re) begin
            r_list_q <= list_mem[ptr_index(r_rd_ptr)];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pt  <= t_point'(s_axis_tdata);
            r_hit <= !w_empty;
        end
        if (r_state == S_IDX && w_idx_res.valid) begin
            r_cell <= w_idx_res.cell_idx;
        end
        if (r_state == S_FLST) begin
            r_cell <= r_list_q;
        end
        if (w_out_load) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_hit ? r_cell_q.pt : '0;
            r_out_last <= r_hit && (ptr_inc(r_rd_ptr) == r_wr_ptr);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tlast  = r_out_last;

    // number of listed cells
    assign w_fill = (r_wr_ptr >= r_rd_ptr) ? r_wr_ptr - r_rd_ptr
                                           : r_wr_ptr + PTR_W'(2 * NUM_CELLS) - r_rd_ptr;

    `GKS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, w_fill <= PTR_CELLS)
    `GKS_ASSERT_IMP(a_out_from_fetch, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FOUT)
    `GKS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_out_valid && !r_out_hit, (r_out_data == '0) && !r_out_last)
    `GKS_ASSERT_NXT(a_pop_advances, i_clk, i_rst_n, w_out_load && r_hit, r_rd_ptr != $past(r_rd_ptr))

endmodule

// ===== tb/sv/grid_keypoint_suppression_test.sv =====
// self-checking testbench of the grid keypoint suppression block
module grid_keypoint_suppression_test;
    import gks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1050;
    // clearing pass plus ~1050 items at worst gap, block and stall, several times over
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int LONG_HOLD   = 300;

    // one fetch answer as it appears on the master side
    typedef struct packed {
        logic   found;
        t_point pt;
        logic   last;
    } t_fetch_answer;

    // mirrors the cell store and the occupancy list, queues the answer of every fetch
    class suppression_scoreboard;
        bit               occupied [NUM_CELLS];
        t_point           best [NUM_CELLS];
        int               first_order [NUM_CELLS];
        int               wr_ptr;
        int               rd_ptr;
        t_fetch_answer    fetch_answers [$];
        int               errors;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            wr_ptr = 0;
            rd_ptr = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return fetch_answers.size();
        endfunction

        // apply one accepted request to the mirrored state
        function void note_request(logic req, t_point pt);
            int            col;
            int            row;
            int            cell_idx;
            t_fetch_answer ans;
            if (req == REQ_INSERT) begin
                col = int'(pt.x_pos) / CELL_SIZE;
                row = int'(pt.y_pos) / CELL_SIZE;
                if (col < GRID_COLS && row < GRID_ROWS) begin
                    cell_idx = row * GRID_COLS + col;
                    if (!occupied[cell_idx]) begin
                        occupied[cell_idx] = 1'b1;
                        best[cell_idx] = pt;
                        first_order[wr_ptr % NUM_CELLS] = cell_idx;
                        wr_ptr = (wr_ptr + 1) % (2 * NUM_CELLS);
                    end else if (pt.strength > best[cell_idx].strength) begin
                        // strictly stronger only, a tie keeps the first
                        best[cell_idx] = pt;
                    end
                end
            end else begin
                ans = '0;
                if (rd_ptr != wr_ptr) begin
                    cell_idx = first_order[rd_ptr % NUM_CELLS];
                    ans.found = 1'b1;
                    ans.pt = best[cell_idx];
                    occupied[cell_idx] = 1'b0;
                    rd_ptr = (rd_ptr + 1) % (2 * NUM_CELLS);
                    ans.last = (rd_ptr == wr_ptr);
                end
                fetch_answers.push_back(ans);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_fetch_result(logic found, t_point pt, logic last);
            t_fetch_answer want;
            if (fetch_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found=%0b x=%0d y=%0d s=%0d",
                         $time, found, pt.x_pos, pt.y_pos, pt.strength);
                return;
            end
            want = fetch_answers.pop_front();
            compare_field("out_valid", 32'(want.found), 32'(found));
            compare_field("out_x", 32'(want.pt.x_pos), 32'(pt.x_pos));
            compare_field("out_y", 32'(want.pt.y_pos), 32'(pt.y_pos));
            compare_field("out_strength", 32'(want.pt.strength), 32'(pt.strength));
            compare_field("out_last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [POINT_W-1:0] s_axis_tdata = '0;   // x_pos, y_pos, strength
    logic               s_axis_tuser = 1'b0; // req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [POINT_W-1:0] m_axis_tdata;        // out_x, out_y, out_strength
    logic               m_axis_tuser;        // out_valid
    logic               m_axis_tlast;        // out_last

    suppression_scoreboard tracker = new();
    int                    items_sent = 0;
    int                    cycles = 0;
    bit                    sender_burst = 1'b0;

    grid_keypoint_suppression u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog, covers the clearing pass after reset
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("grid_keypoint_suppression verification failed");
            $finish;
        end
    end

    // offer one request, hold it until the transaction completes
    // tvalid is only lowered when a gap follows, so back-to-back items keep it high
    task automatic send_request(input logic req, input t_point pt);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= pt;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(req, pt);
        items_sent++;
    endtask

    task automatic insert_at(input int x, input int y, input int s);
        t_point pt;
        pt.x_pos    = COORD_W'(x);
        pt.y_pos    = COORD_W'(y);
        pt.strength = STR_W'(s);
        send_request(REQ_INSERT, pt);
    endtask

    // fetch carries random payload, the block must ignore it
    task automatic fetch_next();
        t_point pt;
        pt.x_pos    = COORD_W'($urandom);
        pt.y_pos    = COORD_W'($urandom);
        pt.strength = STR_W'($urandom);
        send_request(REQ_FETCH, pt);
    endtask

    // result side: random stalls, no-stall stretches and one long hold-off
    initial begin : result_sink
        int hold;
        int taken;
        bit no_stall;
        taken = 0;
        no_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0)
                no_stall = ($urandom_range(0, 3) == 0);
            hold = no_stall ? 0 : $urandom_range(0, 19);
            // long back-pressure, the sender keeps offering so the input stalls
            if (taken == 40)
                hold = LONG_HOLD;
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            tracker.check_fetch_result(m_axis_tuser, t_point'(m_axis_tdata), m_axis_tlast);
            taken++;
        end
    end

    initial begin : stimulus
        int n_ins;
        int n_fetch;
        int base_col;
        int base_row;
        int span;
        int str_base;
        int pick;
        int col;
        int row;
        int s;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list answers with out_valid low
        fetch_next();
        // first keypoint of cell 0, then a tie, a stronger one and a weaker one
        insert_at(0, 0, 0);
        insert_at(9, 9, 0);
        insert_at(5, 3, 65535);
        insert_at(4, 4, 100);
        // last cell of the grid
        insert_at(GRID_COLS * CELL_SIZE - 1, GRID_ROWS * CELL_SIZE - 1, 32768);
        // just outside the grid and the far corner, all dropped
        insert_at(GRID_COLS * CELL_SIZE, 0, 500);
        insert_at(0, GRID_ROWS * CELL_SIZE, 500);
        insert_at(4095, 4095, 65535);
        // the two other grid corners
        insert_at(GRID_COLS * CELL_SIZE - 1, 0, 1);
        insert_at(0, GRID_ROWS * CELL_SIZE - 1, 2);
        // drain in first-occupancy order, last one flagged, then empty again
        repeat (4) fetch_next();
        fetch_next();
        // a fetched cell starts afresh, even with a weaker keypoint
        insert_at(10, 10, 7);
        fetch_next();
        insert_at(12, 15, 3);
        fetch_next();

        // random frames: mostly inserts around a few neighboring cells, then fetches
        while (items_sent < ITEM_TARGET) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            base_col = $urandom_range(0, GRID_COLS - 1);
            base_row = $urandom_range(0, GRID_ROWS - 1);
            span     = $urandom_range(0, 2);
            str_base = $urandom_range(0, 65532);
            n_ins    = $urandom_range(1, 24);
            repeat (n_ins) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    // off the grid in x, in y or in both
                    case ($urandom_range(0, 2))
                        0: insert_at($urandom_range(GRID_COLS * CELL_SIZE, 4095),
                                     $urandom_range(0, GRID_ROWS * CELL_SIZE - 1),
                                     $urandom_range(0, 65535));
                        1: insert_at($urandom_range(0, GRID_COLS * CELL_SIZE - 1),
                                     $urandom_range(GRID_ROWS * CELL_SIZE, 4095),
                                     $urandom_range(0, 65535));
                        default: insert_at($urandom_range(GRID_COLS * CELL_SIZE, 4095),
                                           $urandom_range(GRID_ROWS * CELL_SIZE, 4095),
                                           $urandom_range(0, 65535));
                    endcase
                end else if (pick < 4) begin
                    fetch_next();
                end else if (pick == 4) begin
                    insert_at($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 65535));
                end else begin
                    col = (base_col + $urandom_range(0, span)) % GRID_COLS;
                    row = (base_row + $urandom_range(0, span)) % GRID_ROWS;
                    // narrow strength band makes ties and close calls common
                    s = ($urandom_range(0, 2) == 0) ? str_base + $urandom_range(0, 3)
                                                   : $urandom_range(0, 65535);
                    insert_at(col * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1),
                              row * CELL_SIZE + $urandom_range(0, CELL_SIZE - 1), s);
                end
            end
            // sometimes drain past empty, usually leave some kept points behind
            n_fetch = ($urandom_range(0, 5) == 0) ? n_ins + 6
                                                  : $urandom_range(n_ins / 2, n_ins + 3);
            repeat (n_fetch) fetch_next();
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("grid_keypoint_suppression verification clean");
        end else begin
            $display("grid_keypoint_suppression verification failed");
        end
        $finish;
    end

endmodule
